>>> design/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, constants and small lookup functions shared by the HTTP response
// header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 24;
	localparam int STATUS_W  = 16;
	localparam int LENGTH_W  = 32;
	localparam int VERDICT_W = 2;

	localparam logic [COUNT_W-1:0] CAPACITY_RESET = 24'd65536;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int MAGIC_LEN = 5;
	localparam int FIELD_LEN = 15;
	localparam int STATUS_FIRST = 9;
	localparam int STATUS_LAST = 11;
	localparam int STATUS_MIN_HDR = 12;

	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CHAR_C     = 8'h63;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

	localparam logic signed [STATUS_W-1:0] STATUS_OK        = 16'sd200;
	localparam logic signed [STATUS_W-1:0] STATUS_NOT_FOUND = 16'sd404;
	// Three ASCII zero digits weighted 100, 10 and 1.
	localparam logic [17:0] DIGIT_BIAS = 18'd5328;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_OK        = 2'd0,
		VERDICT_NOT_HTTP  = 2'd1,
		VERDICT_NOT_FOUND = 2'd2,
		VERDICT_REFUSED   = 2'd3
	} verdict_t;

	// Work for the back end: an optional body result and an optional verdict,
	// sharing the counters and parsed fields of the step that made them.
	typedef struct packed {
		logic                       body_v;
		logic [BYTE_W-1:0]          body_byte;
		logic [COUNT_W-1:0]         body_count;
		logic signed [STATUS_W-1:0] status_code;
		logic [LENGTH_W-1:0]        content_length;
		logic                       verdict_v;
		verdict_t                   verdict;
	} job_t;

	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] magic_char(input logic [2:0] i);
		logic [BYTE_W-1:0] r;
		case (i)
			3'd0: r = 8'h68;
			3'd1: r = 8'h74;
			3'd2: r = 8'h74;
			3'd3: r = 8'h70;
			3'd4: r = 8'h2F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] field_char(input logic [3:0] i);
		logic [BYTE_W-1:0] r;
		case (i)
			4'd0:  r = 8'h63;
			4'd1:  r = 8'h6F;
			4'd2:  r = 8'h6E;
			4'd3:  r = 8'h74;
			4'd4:  r = 8'h65;
			4'd5:  r = 8'h6E;
			4'd6:  r = 8'h74;
			4'd7:  r = 8'h2D;
			4'd8:  r = 8'h6C;
			4'd9:  r = 8'h65;
			4'd10: r = 8'h6E;
			4'd11: r = 8'h67;
			4'd12: r = 8'h74;
			4'd13: r = 8'h68;
			4'd14: r = 8'h3A;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> design/hrp_in_if.sv
// ----------------------------------------------------------------------------
// hrp_in_if
// Received byte channel of the HTTP response header parser.
// ----------------------------------------------------------------------------
interface hrp_in_if;
	logic                        valid;
	logic                        ready;
	logic [hrp_pkg::BYTE_W-1:0]  data_byte;
	logic                        byte_valid;
	logic                        closed;

	modport source (output valid, output data_byte, output byte_valid, output closed,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input closed,
		output ready);
endinterface

>>> design/hrp_out_if.sv
// ----------------------------------------------------------------------------
// hrp_out_if
// Result channel of the HTTP response header parser.
// ----------------------------------------------------------------------------
interface hrp_out_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [hrp_pkg::BYTE_W-1:0]          body_byte;
	logic [hrp_pkg::COUNT_W-1:0]         body_count;
	logic signed [hrp_pkg::STATUS_W-1:0] status_code;
	logic [hrp_pkg::LENGTH_W-1:0]        content_length;
	logic [hrp_pkg::VERDICT_W-1:0]       verdict;
	logic                                last;

	modport source (output valid, output kind, output body_byte, output body_count,
		output status_code, output content_length, output verdict, output last,
		input ready);
	modport sink (input valid, input kind, input body_byte, input body_count,
		input status_code, input content_length, input verdict, input last,
		output ready);
endinterface

>>> design/http_response_header_parser_top.sv
// ----------------------------------------------------------------------------
// http_response_header_parser_top
// Takes an HTTP/1.0 reply one byte per item, finds the end of the header
// block, checks the protocol prefix, takes the status code and the first
// content length, passes body bytes on up to the capacity and gives a verdict
// item when the connection closes. One input item is accepted every cycle
// while the job queue has room; an item that yields both a body byte and a
// verdict sends two result items in turn through the single result port, so
// body traffic sustains one item per cycle only while the result side keeps
// ready high and drains the QUEUE_DEPTH-entry queue. Capacity is written
// through cfg_wr_en and cfg_wr_data and resets to 65536.
// ----------------------------------------------------------------------------
module http_response_header_parser_top #(
	parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hrp_in_if.sink                      stream,
	hrp_out_if.source                   result,
	input  logic                        cfg_wr_en,
	input  logic [hrp_pkg::COUNT_W-1:0] cfg_wr_data
);

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	hrp_pkg::job_t wr_job;
	hrp_pkg::job_t head;

	hrp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (stream),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.full        (q_full),
		.push        (q_push),
		.job         (wr_job)
	);

	hrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.pop    (q_pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	hrp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (q_pop),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_body_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.kind |-> result.body_count != '0)
		else $error("body item delivered with a zero body count");

	a_verdict_follows_body: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.kind && head.verdict_v
		|=> result.valid && result.kind && result.last)
		else $error("verdict item did not follow the body item of the same job");
`endif

endmodule

>>> design/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front
// Accepts received bytes, runs the header matchers and body counter, and
// hands a job to the queue for every item that causes a result.
// ----------------------------------------------------------------------------
module hrp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	hrp_in_if.sink                        stream,
	input  logic                          cfg_wr_en,
	input  logic [hrp_pkg::COUNT_W-1:0]   cfg_wr_data,
	input  logic                          full,
	output logic                          push,
	output hrp_pkg::job_t                 job
);

	typedef enum logic [3:0] {
		LP_SEARCH = 4'b0001,
		LP_SKIP   = 4'b0010,
		LP_DIGITS = 4'b0100,
		LP_DONE   = 4'b1000
	} len_phase_t;

	logic [hrp_pkg::COUNT_W-1:0]  cap_q;
	logic                         in_body_q, in_body_d;
	logic [1:0]                   term_q, term_d;
	logic [hrp_pkg::COUNT_W-1:0]  hpos_q, hpos_d;
	logic                         prefix_ok_q, prefix_ok_d;
	logic [3*hrp_pkg::BYTE_W-1:0] sdig_q, sdig_d;
	logic [3:0]                   fmatch_q, fmatch_d;
	len_phase_t                   lphase_q, lphase_d;
	logic [hrp_pkg::LENGTH_W-1:0] lval_q, lval_d;
	logic [hrp_pkg::COUNT_W-1:0]  kept_q, kept_d;

	logic                         acc;
	logic                         body_v;
	logic [hrp_pkg::BYTE_W-1:0]   b, lb, want, digit;
	logic                         is_digit;
	logic                         parsed;
	logic [17:0]                  weighted;
	logic signed [hrp_pkg::STATUS_W-1:0] status;
	hrp_pkg::verdict_t            verdict;

	assign stream.ready = !full;
	assign acc = stream.valid && !full;
	assign b = stream.data_byte;
	assign lb = hrp_pkg::to_lower(b);
	assign is_digit = b inside {[8'h30:8'h39]};
	assign digit = b - hrp_pkg::CHAR_ZERO;

	always_comb begin
		in_body_d = in_body_q;
		term_d = term_q;
		hpos_d = hpos_q;
		prefix_ok_d = prefix_ok_q;
		sdig_d = sdig_q;
		fmatch_d = fmatch_q;
		lphase_d = lphase_q;
		lval_d = lval_q;
		kept_d = kept_q;
		body_v = 1'b0;
		want = term_q[0] ? hrp_pkg::CHAR_LF : hrp_pkg::CHAR_CR;
		if (acc && stream.byte_valid) begin
			if (!in_body_q) begin
				if (hpos_q < cap_q) begin
					if (hpos_q < 24'(hrp_pkg::MAGIC_LEN) &&
						lb != hrp_pkg::magic_char(hpos_q[2:0])) begin
						prefix_ok_d = 1'b0;
					end
					if (hpos_q >= 24'(hrp_pkg::STATUS_FIRST) &&
						hpos_q <= 24'(hrp_pkg::STATUS_LAST)) begin
						sdig_d = {sdig_q[2*hrp_pkg::BYTE_W-1:0], b};
					end
					case (lphase_q)
						LP_SEARCH: begin
							if (lb == hrp_pkg::field_char(fmatch_q)) begin
								if (fmatch_q == 4'(hrp_pkg::FIELD_LEN - 1)) begin
									fmatch_d = '0;
									lphase_d = LP_SKIP;
								end else begin
									fmatch_d = fmatch_q + 4'd1;
								end
							end else begin
								fmatch_d = (lb == hrp_pkg::CHAR_C) ? 4'd1 : 4'd0;
							end
						end
						LP_SKIP: begin
							if (b == hrp_pkg::CHAR_SPACE) begin
								lphase_d = LP_SKIP;
							end else if (is_digit) begin
								lval_d = 32'(digit);
								lphase_d = LP_DIGITS;
							end else begin
								lphase_d = LP_DONE;
							end
						end
						LP_DIGITS: begin
							if (is_digit) begin
								lval_d = (lval_q << 3) + (lval_q << 1) + 32'(digit);
							end else begin
								lphase_d = LP_DONE;
							end
						end
						default: begin
							lphase_d = lphase_q;
						end
					endcase
					hpos_d = hpos_q + 24'd1;
					if (b == want) begin
						if (term_q == 2'd3) begin
							term_d = 2'd0;
							in_body_d = 1'b1;
						end else begin
							term_d = term_q + 2'd1;
						end
					end else begin
						term_d = (b == hrp_pkg::CHAR_CR) ? 2'd1 : 2'd0;
					end
				end
			end else if (kept_q < cap_q) begin
				kept_d = kept_q + 24'd1;
				body_v = 1'b1;
			end
		end
	end

	// The status digits are only meaningful once the split has been seen on a
	// header block that started with the protocol name and is long enough.
	assign parsed = in_body_d && prefix_ok_d && hpos_d >= 24'(hrp_pkg::STATUS_MIN_HDR);
	assign weighted = 18'(sdig_d[23:16]) * 18'd100 + 18'(sdig_d[15:8]) * 18'd10
		+ 18'(sdig_d[7:0]);
	assign status = parsed ? signed'(16'(weighted - hrp_pkg::DIGIT_BIAS)) : 16'sd0;

	always_comb begin
		if (!in_body_d) begin
			verdict = hrp_pkg::VERDICT_NOT_HTTP;
		end else if (status != 16'sd0 && status != hrp_pkg::STATUS_OK) begin
			verdict = (status == hrp_pkg::STATUS_NOT_FOUND) ? hrp_pkg::VERDICT_NOT_FOUND
				: hrp_pkg::VERDICT_REFUSED;
		end else begin
			verdict = hrp_pkg::VERDICT_OK;
		end
	end

	assign push = acc && (body_v || stream.closed);

	always_comb begin
		job.body_v = body_v;
		job.body_byte = b;
		job.body_count = kept_d;
		job.status_code = status;
		job.content_length = in_body_d ? lval_d : '0;
		job.verdict_v = stream.closed;
		job.verdict = verdict;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= hrp_pkg::CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			term_q <= '0;
			hpos_q <= '0;
			prefix_ok_q <= 1'b1;
			sdig_q <= '0;
			fmatch_q <= '0;
			lphase_q <= LP_SEARCH;
			lval_q <= '0;
			kept_q <= '0;
		end else if (acc) begin
			if (stream.closed) begin
				// A closed connection ends the stream; the next item starts afresh.
				in_body_q <= 1'b0;
				term_q <= '0;
				hpos_q <= '0;
				prefix_ok_q <= 1'b1;
				sdig_q <= '0;
				fmatch_q <= '0;
				lphase_q <= LP_SEARCH;
				lval_q <= '0;
				kept_q <= '0;
			end else begin
				in_body_q <= in_body_d;
				term_q <= term_d;
				hpos_q <= hpos_d;
				prefix_ok_q <= prefix_ok_d;
				sdig_q <= sdig_d;
				fmatch_q <= fmatch_d;
				lphase_q <= lphase_d;
				lval_q <= lval_d;
				kept_q <= kept_d;
			end
		end
	end

endmodule

>>> design/hrp_queue.sv
// ----------------------------------------------------------------------------
// hrp_queue
// Short queue of jobs between the parsing front end and the result back end.
// ----------------------------------------------------------------------------
module hrp_queue #(
	parameter int DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hrp_pkg::job_t wr_job,
	input  logic          pop,
	output hrp_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hrp_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back
// Turns the job at the head of the queue into one or two result items.
// ----------------------------------------------------------------------------
module hrp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  hrp_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	hrp_out_if.source     result
);

	// Set once the body item of a job that also carries a verdict has gone.
	logic phase_q;
	logic sel_body;
	logic taken;

	assign sel_body = head.body_v && !phase_q;
	assign taken = result.valid && result.ready;
	assign pop = taken && !(sel_body && head.verdict_v);

	assign result.valid = !empty;
	assign result.kind = !sel_body;
	assign result.body_byte = sel_body ? head.body_byte : '0;
	assign result.body_count = head.body_count;
	assign result.status_code = head.status_code;
	assign result.content_length = head.content_length;
	assign result.verdict = sel_body ? hrp_pkg::VERDICT_OK : head.verdict;
	assign result.last = !sel_body;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (taken) begin
			phase_q <= !pop;
		end
	end

endmodule

>>> tb/reply_parse_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reply_parse_monitor
// Watches the byte and result channels of the HTTP response header parser,
// keeps its own copy of the parser state and capacity, predicts the result
// items of every accepted byte item and compares them in order with what the
// block delivers. The error count and the number of outstanding results are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module reply_parse_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	hrp_in_if                           stream,
	hrp_out_if                          result,
	input  logic                        cfg_wr_en,
	input  logic [hrp_pkg::COUNT_W-1:0] cfg_wr_data,
	output int                          error_count,
	output int                          pending_count
);
	import hrp_pkg::*;

	localparam logic [39:0]  PREFIX_TEXT = "http/";
	localparam logic [119:0] FIELD_TEXT  = "content-length:";
	localparam logic [7:0]   CHAR_NINE   = "9";
	localparam int           REPORT_MAX  = 10;

	typedef enum logic [1:0] {
		LEN_SEARCH,
		LEN_SPACES,
		LEN_DIGITS,
		LEN_DONE
	} length_phase_t;

	typedef struct packed {
		logic                       kind;
		logic [BYTE_W-1:0]          body_byte;
		logic [COUNT_W-1:0]         body_count;
		logic signed [STATUS_W-1:0] status_code;
		logic [LENGTH_W-1:0]        content_length;
		verdict_t                   verdict;
		logic                       last;
	} parse_result_t;

	parse_result_t expected_results[$];

	logic [COUNT_W-1:0]  capacity;
	logic                in_body;
	logic [1:0]          crlf_match;
	logic [COUNT_W-1:0]  hdr_pos;
	logic                prefix_ok;
	logic [23:0]         status_chars;
	logic [3:0]          name_match;
	length_phase_t       len_phase;
	logic [LENGTH_W-1:0] len_value;
	logic [COUNT_W-1:0]  kept_count;
	int                  mismatches;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void clear_stream();
		in_body      = 1'b0;
		crlf_match   = 2'd0;
		hdr_pos      = '0;
		prefix_ok    = 1'b1;
		status_chars = '0;
		name_match   = 4'd0;
		len_phase    = LEN_SEARCH;
		len_value    = '0;
		kept_count   = '0;
	endfunction

	// The status only counts once the split is found, the prefix held and the
	// header block reached twelve bytes.
	function automatic int current_status();
		if (!(in_body && prefix_ok && hdr_pos >= COUNT_W'(STATUS_MIN_HDR))) begin
			return 0;
		end
		return (int'(status_chars[23:16]) - 48) * 100 + (int'(status_chars[15:8]) - 48) * 10
			+ (int'(status_chars[7:0]) - 48);
	endfunction

	function automatic parse_result_t make_result(input logic kind, input logic [7:0] b,
		input verdict_t v, input logic last);
		parse_result_t r;
		int s;
		s = current_status();
		r.kind           = kind;
		r.body_byte      = b;
		r.body_count     = kept_count;
		r.status_code    = s[15:0];
		r.content_length = in_body ? len_value : '0;
		r.verdict        = v;
		r.last           = last;
		return r;
	endfunction

	function automatic void predict_item(input logic [7:0] b, input logic bv, input logic cl);
		logic [7:0] lb;
		logic [7:0] want;
		int pos;
		int s;
		verdict_t v;
		lb = fold_case(b);
		pos = int'(hdr_pos);
		if (bv) begin
			if (!in_body) begin
				if (hdr_pos < capacity) begin
					if (pos < MAGIC_LEN && lb != PREFIX_TEXT[8*(4-pos) +: 8]) begin
						prefix_ok = 1'b0;
					end
					if (pos >= STATUS_FIRST && pos <= STATUS_LAST) begin
						status_chars = {status_chars[15:0], b};
					end
					case (len_phase)
						LEN_SEARCH: begin
							if (lb == FIELD_TEXT[8*(14-int'(name_match)) +: 8]) begin
								if (name_match == 4'd14) begin
									name_match = 4'd0;
									len_phase  = LEN_SPACES;
								end else begin
									name_match = name_match + 4'd1;
								end
							end else begin
								// A stray 'c' may already open a new match.
								name_match = (lb == CHAR_C) ? 4'd1 : 4'd0;
							end
						end
						LEN_SPACES: begin
							if (b != CHAR_SPACE) begin
								if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
									len_value = LENGTH_W'(b - CHAR_ZERO);
									len_phase = LEN_DIGITS;
								end else begin
									len_phase = LEN_DONE;
								end
							end
						end
						LEN_DIGITS: begin
							if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
								len_value = len_value * 32'd10 + LENGTH_W'(b - CHAR_ZERO);
							end else begin
								len_phase = LEN_DONE;
							end
						end
						default: begin
						end
					endcase
					hdr_pos = hdr_pos + COUNT_W'(1);
					want = crlf_match[0] ? CHAR_LF : CHAR_CR;
					if (b == want) begin
						if (crlf_match == 2'd3) begin
							crlf_match = 2'd0;
							in_body    = 1'b1;
						end else begin
							crlf_match = crlf_match + 2'd1;
						end
					end else begin
						crlf_match = (b == CHAR_CR) ? 2'd1 : 2'd0;
					end
				end
			end else if (kept_count < capacity) begin
				kept_count = kept_count + COUNT_W'(1);
				expected_results.push_back(make_result(1'b0, b, VERDICT_OK, 1'b0));
			end
		end
		if (cl) begin
			s = current_status();
			if (!in_body) begin
				v = VERDICT_NOT_HTTP;
			end else if (s != 0 && s != int'(STATUS_OK)) begin
				v = (s == int'(STATUS_NOT_FOUND)) ? VERDICT_NOT_FOUND : VERDICT_REFUSED;
			end else begin
				v = VERDICT_OK;
			end
			expected_results.push_back(make_result(1'b1, 8'h00, v, 1'b1));
			clear_stream();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		parse_result_t got;
		parse_result_t exp_item;
		if (!arst_n) begin
			capacity = CAPACITY_RESET;
			clear_stream();
			expected_results.delete();
			mismatches = 0;
			error_count   <= 0;
			pending_count <= 0;
		end else begin
			if (stream.valid && stream.ready) begin
				predict_item(stream.data_byte, stream.byte_valid, stream.closed);
			end
			// A capacity written at this edge only applies to later items.
			if (cfg_wr_en) begin
				capacity = cfg_wr_data;
			end
			if (result.valid && result.ready) begin
				got.kind           = result.kind;
				got.body_byte      = result.body_byte;
				got.body_count     = result.body_count;
				got.status_code    = result.status_code;
				got.content_length = result.content_length;
				got.verdict        = verdict_t'(result.verdict);
				got.last           = result.last;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("%0t: result item with nothing expected: %p", $realtime, got);
					end
				end else begin
					exp_item = expected_results.pop_front();
					if (got !== exp_item) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: result mismatch (expected/actual)", $realtime);
							$display("  kind %0d/%0d byte %02h/%02h count %0d/%0d last %0d/%0d",
								exp_item.kind, got.kind, exp_item.body_byte, got.body_byte,
								exp_item.body_count, got.body_count, exp_item.last, got.last);
							$display("  status %0d/%0d length %0d/%0d verdict %s/%s",
								exp_item.status_code, got.status_code, exp_item.content_length,
								got.content_length, exp_item.verdict.name(), got.verdict.name());
						end
					end
				end
			end
			error_count   <= mismatches;
			pending_count <= expected_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives HTTP replies into the response header parser one byte item at a
// time: a few directed streams, then phases of random replies under changing
// capacities, with random gaps on the byte channel and random stalls on the
// result channel. Prediction and comparison sit in reply_parse_monitor.
// ----------------------------------------------------------------------------
module testbench;
	import hrp_pkg::*;

	localparam int ITEM_TARGET    = 2000;
	localparam int CFG_SETTLE     = 16;
	localparam int DRAIN_CYCLES   = 32;
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;
	int                 error_count;
	int                 pending_count;
	int                 items_sent = 0;
	int                 idle_cycles = 0;
	bit                 feed_gaps = 1'b1;
	bit                 drain_stalls = 1'b1;
	logic [7:0]         reply_bytes[$];

	hrp_in_if  stream_ch ();
	hrp_out_if result_ch ();

	http_response_header_parser_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (stream_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	reply_parse_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream        (stream_ch),
		.result        (result_ch),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Entered and left at a falling edge; valid stays high when no gap is drawn.
	task automatic send_item(input logic [7:0] b, input logic bv, input logic cl);
		int gap;
		gap = feed_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			stream_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_ch.valid      <= 1'b1;
		stream_ch.data_byte  <= b;
		stream_ch.byte_valid <= bv;
		stream_ch.closed     <= cl;
		@(posedge clk);
		while (!stream_ch.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		reply_bytes.push_back(b);
	endtask

	task automatic add_crlf();
		reply_bytes.push_back(CHAR_CR);
		reply_bytes.push_back(CHAR_LF);
	endtask

	task automatic add_text(input string s, input bit mixed);
		int i;
		logic [7:0] c;
		for (i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mixed && $urandom_range(0, 1)) begin
				if (c >= "a" && c <= "z") begin
					c = c - 8'd32;
				end else if (c >= "A" && c <= "Z") begin
					c = c + 8'd32;
				end
			end
			reply_bytes.push_back(c);
		end
	endtask

	task automatic build_reply();
		int flavour;
		int n;
		int i;
		int cut;
		string near_name;
		reply_bytes.delete();
		near_name = "content-length:";
		flavour = $urandom_range(0, 9);
		if (flavour == 0) begin
			// Noise with plenty of line ends in it.
			n = $urandom_range(0, 30);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(0, 3))
					0: add_byte(CHAR_CR);
					1: add_byte(CHAR_LF);
					default: add_byte(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			add_text("http/", 1'b1);
			if ($urandom_range(0, 7) == 0) begin
				reply_bytes[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
			end
			if (flavour == 1) begin
				// Header blocks just under, at and just over the status minimum.
				case ($urandom_range(0, 2))
					0: add_text("1", 1'b0);
					1: add_text("1.0", 1'b0);
					default: add_text("1.0 2", 1'b0);
				endcase
				add_crlf();
				add_crlf();
			end else begin
				add_text("1.0 ", 1'b0);
				case ($urandom_range(0, 5))
					0: add_text("200", 1'b0);
					1: add_text("404", 1'b0);
					2: add_text("000", 1'b0);
					3: begin
						repeat (3) add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
					end
					default: begin
						repeat (3) add_byte(8'($urandom_range(0, 255)));
					end
				endcase
				add_text(" ok", 1'b1);
				add_crlf();
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 4))
						0: begin
							add_text("content-length:", 1'b1);
							repeat ($urandom_range(0, 3)) add_byte(CHAR_SPACE);
							repeat ($urandom_range(0, 12)) add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
							if ($urandom_range(0, 3) == 0) begin
								add_text(";x", 1'b0);
							end
						end
						1: add_text("server: t", 1'b1);
						2: begin
							// A broken-off field name followed straight by the real one.
							cut = $urandom_range(1, 14);
							add_text(near_name.substr(0, cut - 1), 1'b1);
							add_text("content-length: 7", 1'b1);
						end
						3: add_text("content-length:x1", 1'b1);
						default: begin
							add_text("x-a: ", 1'b0);
							add_byte(CHAR_CR);
						end
					endcase
					add_crlf();
				end
				if ($urandom_range(0, 9) == 0) begin
					// The header block is left unterminated.
					if ($urandom_range(0, 1)) begin
						add_byte(CHAR_CR);
					end
				end else begin
					add_crlf();
				end
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_reply();
		int i;
		bit close_on_byte;
		close_on_byte = $urandom_range(0, 1);
		for (i = 0; i < reply_bytes.size(); i++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_item(reply_bytes[i], 1'b1, close_on_byte && i == reply_bytes.size() - 1);
		end
		if (!close_on_byte || reply_bytes.size() == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	// Lets the block run dry: every predicted result in, then a few more cycles
	// for header items that produce nothing.
	task automatic settle_block(input int extra);
		stream_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	initial begin : result_drain
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = drain_stalls ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase;
		arst_n               = 1'b0;
		stream_ch.valid      = 1'b0;
		stream_ch.data_byte  = '0;
		stream_ch.byte_valid = 1'b0;
		stream_ch.closed     = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// A not-found reply whose close item also carries a body byte,
		// with an ignored item in between.
		reply_bytes.delete();
		add_text("hTtP/1.0 404", 1'b0);
		add_crlf();
		add_crlf();
		foreach (reply_bytes[i]) send_item(reply_bytes[i], 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// A stream that closes before any byte.
		send_item(8'h00, 1'b0, 1'b1);
		// A bare terminator: too short for a status.
		reply_bytes.delete();
		add_crlf();
		add_crlf();
		foreach (reply_bytes[i]) send_item(reply_bytes[i], 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle_block(CFG_SETTLE);
			case (phase % 6)
				0: cfg_wr_data <= CAPACITY_RESET;
				1: cfg_wr_data <= COUNT_W'(1);
				2: cfg_wr_data <= {COUNT_W{1'b1}};
				3: cfg_wr_data <= COUNT_W'($urandom_range(2, 12));
				4: cfg_wr_data <= COUNT_W'($urandom_range(20, 60));
				default: cfg_wr_data <= COUNT_W'($urandom_range(1, 24'hFFFFFF));
			endcase
			cfg_wr_en <= 1'b1;
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			feed_gaps    = ($urandom_range(0, 3) != 0);
			drain_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(4, 8)) begin
				build_reply();
				send_reply();
			end
			phase++;
		end

		settle_block(DRAIN_CYCLES);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> http_response_header_parser_top.f
design/hrp_pkg.sv
design/hrp_in_if.sv
design/hrp_out_if.sv
design/hrp_front.sv
design/hrp_queue.sv
design/hrp_back.sv
design/http_response_header_parser_top.sv
tb/reply_parse_monitor.sv
tb/testbench.sv
